// ===== rtl/rgbmed_pkg.sv =====
// shared types, constants and helper functions for the rgb 3x3 median filter
// no dependencies; imported by every module of the block but rgbmed_line_mem
`default_nettype none

package rgbmed_pkg;

	localparam int DEF_MAX_WIDTH      = 1024;
	localparam int RESET_FRAME_WIDTH  = 640;
	localparam int RESET_FRAME_HEIGHT = 480;

	// row position runs one past the bottom edge plus one while draining
	localparam int ROW_W     = 17;
	localparam int HEIGHT_W  = 16;
	localparam int WIDTH_W   = 11;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	// one channel of a window column, sorted low to high
	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] md;
		logic [7:0] hi;
	} sorted3_t;

	typedef struct packed {
		sorted3_t r;
		sorted3_t g;
		sorted3_t b;
	} col_t;

	// edge replication of the window columns
	typedef struct packed {
		logic left_clamp;
		logic right_clamp;
	} win_ctl_t;

	function automatic sorted3_t sort3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		logic [7:0] x0, x1, x2, t;
		sorted3_t s;
		x0 = a;
		x1 = b;
		x2 = c;
		if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
		if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
		if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
		s.lo = x0;
		s.md = x1;
		s.hi = x2;
		return s;
	endfunction

	function automatic logic [7:0] med3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		logic [7:0] lo_ab, hi_ab, lo_hc;
		lo_ab = (a < b) ? a : b;
		hi_ab = (a < b) ? b : a;
		lo_hc = (hi_ab < c) ? hi_ab : c;
		return (lo_ab > lo_hc) ? lo_ab : lo_hc;
	endfunction

	// last column index: zero acts as one, wide frames clip to the line store
	function automatic int eff_width_last(logic [WIDTH_W-1:0] raw, int max_w);
		int w;
		w = int'(raw);
		if (w == 0) w = 1;
		if (w > max_w) w = max_w;
		return w - 1;
	endfunction

	// last row index: zero acts as one
	function automatic logic [HEIGHT_W-1:0] eff_height_last(logic [HEIGHT_W-1:0] raw);
		return (raw == '0) ? '0 : raw - HEIGHT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbmed_line_mem.sv =====
// single line store: one write port, one read port with registered read data
// uses no package; instantiated by the filter core for each buffered row
`default_nettype none

module rgbmed_line_mem #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 24,
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;

	// read returns the contents from before a same-cycle write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== rtl/rgbmed_col_sort.sv =====
// sorts one vertical window column per color channel
// depends on rgbmed_pkg (pixel_t, col_t, sort3)
`default_nettype none

module rgbmed_col_sort import rgbmed_pkg::*; (
	input  wire pixel_t top,
	input  wire pixel_t mid,
	input  wire pixel_t bot,
	output col_t        col
);

	always_comb begin
		col.r = sort3(top.r, mid.r, bot.r);
		col.g = sort3(top.g, mid.g, bot.g);
		col.b = sort3(top.b, mid.b, bot.b);
	end

endmodule

`default_nettype wire

// ===== rtl/rgbmed_median_sel.sv =====
// median of nine from three presorted columns, with left/right edge replication
// depends on rgbmed_pkg (col_t, win_ctl_t, pixel_t, med3)
`default_nettype none

module rgbmed_median_sel import rgbmed_pkg::*; (
	input  wire col_t [2:0] win,
	input  wire win_ctl_t   ctl,
	output pixel_t          pix
);

	col_t left, center, right;

	// max of lows, median of middles, min of highs, then median of those
	function automatic logic [7:0] med9(sorted3_t a, sorted3_t b, sorted3_t c);
		logic [7:0] lo_ab, max_lo, hi_ab, min_hi, mid_md;
		lo_ab  = (a.lo > b.lo) ? a.lo : b.lo;
		max_lo = (lo_ab > c.lo) ? lo_ab : c.lo;
		hi_ab  = (a.hi < b.hi) ? a.hi : b.hi;
		min_hi = (hi_ab < c.hi) ? hi_ab : c.hi;
		mid_md = med3(a.md, b.md, c.md);
		return med3(max_lo, mid_md, min_hi);
	endfunction

	always_comb begin
		center = win[1];
		left   = ctl.left_clamp  ? win[1] : win[2];
		right  = ctl.right_clamp ? win[1] : win[0];
		pix.r  = med9(left.r, center.r, right.r);
		pix.g  = med9(left.g, center.g, right.g);
		pix.b  = med9(left.b, center.b, right.b);
	end

endmodule

`default_nettype wire

// ===== rtl/rgb_median3x3_filter_core.sv =====
// top level of the rgb 3x3 median filter: position counters, line stores,
// window pipeline and output register
// depends on rgbmed_pkg, rgbmed_line_mem, rgbmed_col_sort, rgbmed_median_sel
//
// usage
// - input channel (in_valid/in_ready): command selects a pixel item or a
//   drain item; pixels come in raster order, frame_width by frame_height
// - output channel (out_valid/out_ready): one filtered pixel per result,
//   end_of_frame marks the bottom-right pixel of the frame
// - result for pixel p is produced by the item that carries pixel
//   p + frame_width + 1; after the last pixel, each drain item (or any item)
//   pushes out one of the remaining frame_width + 1 results
// - a result passes the stage 1 register, the window registers and the output
//   register to out_*; throughput is one item per clock unless out_ready stalls
//   the pipeline; the single stall bubble follows the last pixel of a one-row
//   frame, where an internal step loads the first window column before draining
// - config port writes frame_width / frame_height and restarts the frame;
//   only write while no result is pending
// - reset clears the position counters and pipeline valids, and loads a
//   640 x 480 frame; the line stores are not cleared (unwritten data is unused)
// - when out_ready is low the output register holds, the pipeline fills
//   behind it and in_ready drops once every stage holds an item
`default_nettype none

module rgb_median3x3_filter_core import rgbmed_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input items
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 command,
	input  wire logic [7:0]           red_in,
	input  wire logic [7:0]           green_in,
	input  wire logic [7:0]           blue_in,
	// result items
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [7:0]           red_out,
	output logic      [7:0]           green_out,
	output logic      [7:0]           blue_out,
	output logic                      end_of_frame
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	localparam logic [COL_W-1:0] W_LAST_RST =
		COL_W'(eff_width_last(WIDTH_W'(RESET_FRAME_WIDTH), MAX_WIDTH));
	localparam logic [HEIGHT_W-1:0] H_LAST_RST =
		eff_height_last(HEIGHT_W'(RESET_FRAME_HEIGHT));

	// one window step on its way from the counters to the window registers
	typedef struct packed {
		pixel_t           pix;
		logic [COL_W-1:0] col;
		logic             drain;      // virtual step below the frame, no write
		logic             top_upper;  // top row from the upper store
		logic             emit;
		logic             eof;
		win_ctl_t         ctl;
		logic             fwd;        // read address matched last write
		pixel_t           fwd_lower;
		pixel_t           fwd_upper;
	} step_t;

	// config and position
	logic [COL_W-1:0]    w_last_q;
	logic [HEIGHT_W-1:0] h_last_q;
	logic [ROW_W-1:0]    in_row_q;
	logic [COL_W-1:0]    in_col_q;
	logic [ROW_W-1:0]    h_ext;

	// pipeline
	logic       valid_s1;
	step_t      step_s1;
	step_t      step_nxt;
	logic       valid_s2;
	col_t [2:0] win_s2;
	win_ctl_t   ctl_s2;
	logic       eof_s2;
	logic       out_valid_q;
	pixel_t     out_pix_q;
	logic       out_eof_q;

	// handshake and step control
	logic out_free, move_s1, move_s2;
	logic drain_phase, emit_now, auto_step, accept, step, eof_now;

	// line stores
	pixel_t lower_rd, upper_rd, lower_eff, upper_eff;
	pixel_t col_top, col_bot;
	logic   wr_en;
	col_t   col_new;
	pixel_t med_pix;

	// ------------------------------------------------------------------
	// flow control: each stage moves when the one after it can take it
	// ------------------------------------------------------------------
	always_comb begin
		out_free = !out_valid_q || out_ready;
		move_s2  = !valid_s2 || out_free;
		move_s1  = !valid_s1 || move_s2;
	end

	// ------------------------------------------------------------------
	// step decode from the position of the next item
	// rows past the last one are virtual rows that flush the window
	// ------------------------------------------------------------------
	always_comb begin
		h_ext       = {1'b0, h_last_q};
		drain_phase = in_row_q > h_ext;
		emit_now    = (in_row_q >= ROW_W'(2)) ||
		              ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
		// one-row frame: first virtual column carries no result, do it unasked
		auto_step   = drain_phase && !emit_now;
		eof_now     = drain_phase && (in_row_q == h_ext + ROW_W'(2)) && (in_col_q == '0);
		in_ready    = move_s1 && !auto_step;
		accept      = in_valid && in_ready;
		// a drain item before the frame end is consumed with no effect
		step        = move_s1 &&
		              (auto_step || (accept && (drain_phase || command == CMD_PIXEL)));
	end

	// ------------------------------------------------------------------
	// configuration and position counters
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= W_LAST_RST;
			h_last_q <= H_LAST_RST;
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					w_last_q <= COL_W'(eff_width_last(cfg_data[WIDTH_W-1:0], MAX_WIDTH));
				end
				CFG_FRAME_HEIGHT: begin
					h_last_q <= eff_height_last(cfg_data[HEIGHT_W-1:0]);
				end
				default: begin
				end
			endcase
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (step) begin
			if (eof_now) begin
				in_row_q <= '0;
				in_col_q <= '0;
			end else if (in_col_q == w_last_q) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + ROW_W'(1);
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// line stores: lower holds the previous row, upper the one before;
	// a pixel writes itself to lower and moves the old lower entry up
	// ------------------------------------------------------------------
	always_comb begin
		lower_eff = step_s1.fwd ? step_s1.fwd_lower : lower_rd;
		upper_eff = step_s1.fwd ? step_s1.fwd_upper : upper_rd;
		wr_en     = valid_s1 && move_s2 && !step_s1.drain;
	end

	rgbmed_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W ($bits(pixel_t)),
		.ADDR_W (COL_W)
	) u_lower_mem (
		.clk     (clk),
		.rd_en   (step),
		.rd_addr (in_col_q),
		.rd_data (lower_rd),
		.wr_en   (wr_en),
		.wr_addr (step_s1.col),
		.wr_data (step_s1.pix)
	);

	rgbmed_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W ($bits(pixel_t)),
		.ADDR_W (COL_W)
	) u_upper_mem (
		.clk     (clk),
		.rd_en   (step),
		.rd_addr (in_col_q),
		.rd_data (upper_rd),
		.wr_en   (wr_en),
		.wr_addr (step_s1.col),
		.wr_data (lower_eff)
	);

	// ------------------------------------------------------------------
	// stage 1: step registered alongside the line store read
	// ------------------------------------------------------------------
	always_comb begin
		step_nxt.pix             = '{r: red_in, g: green_in, b: blue_in};
		step_nxt.col             = in_col_q;
		step_nxt.drain           = drain_phase;
		step_nxt.top_upper       = in_row_q >= ROW_W'(2);
		step_nxt.emit            = emit_now;
		step_nxt.eof             = eof_now;
		// output column is one left of the incoming one; column zero wraps
		// to the last output column of the row above
		step_nxt.ctl.left_clamp  = (in_col_q == COL_W'(1)) || (w_last_q == '0);
		step_nxt.ctl.right_clamp = in_col_q == '0;
		// same-address write this cycle is not yet in the read data
		step_nxt.fwd             = wr_en && (step_s1.col == in_col_q);
		step_nxt.fwd_lower       = step_s1.pix;
		step_nxt.fwd_upper       = lower_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (move_s1) begin
			valid_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			step_s1 <= step_nxt;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: build the new column (top and bottom edge replication),
	// sort it and shift it into the three-column window
	// ------------------------------------------------------------------
	always_comb begin
		col_top = step_s1.top_upper ? upper_eff : lower_eff;
		col_bot = step_s1.drain ? lower_eff : step_s1.pix;
	end

	rgbmed_col_sort u_col_sort (
		.top (col_top),
		.mid (lower_eff),
		.bot (col_bot),
		.col (col_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s2) begin
			valid_s2 <= valid_s1 && step_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && move_s2) begin
			win_s2[0] <= col_new;
			win_s2[1] <= win_s2[0];
			win_s2[2] <= win_s2[1];
			ctl_s2    <= step_s1.ctl;
			eof_s2    <= step_s1.eof;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: median of the window into the output register
	// ------------------------------------------------------------------
	rgbmed_median_sel u_median_sel (
		.win (win_s2),
		.ctl (ctl_s2),
		.pix (med_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			out_pix_q <= med_pix;
			out_eof_q <= eof_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign red_out      = out_pix_q.r;
	assign green_out    = out_pix_q.g;
	assign blue_out     = out_pix_q.b;
	assign end_of_frame = out_eof_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	// column position stays inside the configured row
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= w_last_q)
		else $error("column position beyond frame width");

	// row position never runs past the final flush row
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= {1'b0, h_last_q} + ROW_W'(2))
		else $error("row position beyond flush row");

	// a stalled result keeps its window
	a_win_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(win_s2) && $stable(ctl_s2))
		else $error("window changed under a stalled result");

	// the end-of-frame step restarts the frame
	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && eof_now |=> in_row_q == '0 && in_col_q == '0)
		else $error("frame not restarted after end of frame");

endmodule

`default_nettype wire

// ===== tb/rgbmed_sb_pkg.sv =====
// scoreboard for the rgb 3x3 median filter: frame-position predictor and result check
// depends on rgbmed_pkg for pixel_t, the command codes and the register indexes
`timescale 1ns / 100ps

package rgbmed_sb_pkg;
	import rgbmed_pkg::*;

	// raster positions wrap in this buffer; a window never spans more than 2*width+2
	localparam int HIST_DEPTH  = 4096;
	localparam int MAX_PRINTED = 30;

	class median_scoreboard;
		typedef struct packed {
			logic [7:0] red;
			logic [7:0] green;
			logic [7:0] blue;
			logic       eof;
		} filtered_t;

		logic [WIDTH_W-1:0]  width_reg;
		logic [HEIGHT_W-1:0] height_reg;
		int                  in_row, in_col, out_row, out_col;
		pixel_t              frame_buf [HIST_DEPTH];
		filtered_t           filtered_q [$];
		int unsigned         errors, checked, frames_done, pixel_items, drain_items;

		function new();
			width_reg   = WIDTH_W'(RESET_FRAME_WIDTH);
			height_reg  = HEIGHT_W'(RESET_FRAME_HEIGHT);
			errors      = 0;
			checked     = 0;
			frames_done = 0;
			pixel_items = 0;
			drain_items = 0;
			restart_frame();
		endfunction

		function int eff_width();
			int w;
			w = int'(width_reg);
			if (w == 0) w = 1;
			if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
			return w;
		endfunction

		function int eff_height();
			return (height_reg == '0) ? 1 : int'(height_reg);
		endfunction

		function void restart_frame();
			in_row  = 0;
			in_col  = 0;
			out_row = 0;
			out_col = 0;
		endfunction

		function int unsigned pending();
			return filtered_q.size();
		endfunction

		// any write restarts the frame, pending positions are dropped
		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_FRAME_WIDTH)
				width_reg = data[WIDTH_W-1:0];
			else
				height_reg = data[HEIGHT_W-1:0];
			restart_frame();
		endfunction

		// neighbor with row and column clamped into the frame
		function pixel_t fetch_clamped(int r, int c, int w, int h, int received);
			int pos;
			if (r < 0) r = 0;
			if (r > h - 1) r = h - 1;
			if (c < 0) c = 0;
			if (c > w - 1) c = w - 1;
			pos = r * w + c;
			if (pos >= received) return '0;
			return frame_buf[pos % HIST_DEPTH];
		endfunction

		// value whose rank among the nine covers the middle slot
		function logic [7:0] median_of_nine(logic [8:0][7:0] v);
			int below, at_most;
			for (int i = 0; i < 9; i++) begin
				below   = 0;
				at_most = 0;
				for (int j = 0; j < 9; j++) begin
					if (v[j] < v[i]) below++;
					if (v[j] <= v[i]) at_most++;
				end
				if (below <= 4 && at_most >= 5) return v[i];
			end
			return v[0];
		endfunction

		function void emit_result(int received);
			int              w, h;
			pixel_t          p;
			logic [8:0][7:0] rs, gs, bs;
			filtered_t       res;
			w = eff_width();
			h = eff_height();
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					p = fetch_clamped(out_row + a - 1, out_col + b - 1, w, h, received);
					rs[a * 3 + b] = p.r;
					gs[a * 3 + b] = p.g;
					bs[a * 3 + b] = p.b;
				end
			end
			res.red   = median_of_nine(rs);
			res.green = median_of_nine(gs);
			res.blue  = median_of_nine(bs);
			res.eof   = (out_row == h - 1) && (out_col == w - 1);
			filtered_q.push_back(res);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
			if (res.eof) restart_frame();
		endfunction

		function void note_item(logic cmd, pixel_t px);
			int w, h, k;
			w = eff_width();
			h = eff_height();
			if (cmd == CMD_PIXEL) pixel_items++;
			else drain_items++;
			// past the last pixel every item pushes out one pending result
			if (in_row >= h) begin
				if (out_row < h) emit_result(h * w);
				else restart_frame();
				return;
			end
			if (cmd == CMD_DRAIN) return;
			k = in_row * w + in_col;
			frame_buf[k % HIST_DEPTH] = px;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (k >= w + 1) emit_result(k + 1);
		endfunction

		task report_mismatch(string msg);
			if (errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(logic [7:0] red, logic [7:0] green, logic [7:0] blue, logic eof);
			filtered_t want;
			if (filtered_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result rgb %0d/%0d/%0d eof %0b",
					red, green, blue, eof));
				return;
			end
			want = filtered_q.pop_front();
			checked++;
			if (want.eof) frames_done++;
			if (red !== want.red || green !== want.green || blue !== want.blue
					|| eof !== want.eof)
				report_mismatch($sformatf(
					"result %0d: got rgb %0d/%0d/%0d eof %0b, want %0d/%0d/%0d eof %0b",
					checked, red, green, blue, eof,
					want.red, want.green, want.blue, want.eof));
		endtask
	endclass

endpackage

// ===== tb/tb_top.sv =====
// testbench top for rgb_median3x3_filter_core: directed frames, then random frames
// with idling and back-pressure on both channels, checked by median_scoreboard
// depends on rgbmed_pkg, rgbmed_sb_pkg and the rtl of the filter
`timescale 1ns / 100ps

module tb_top;
	import rgbmed_pkg::*;
	import rgbmed_sb_pkg::*;

	// random part length in items, last stretch of it runs without idling
	localparam int unsigned RANDOM_ITEMS = 1650;
	localparam int unsigned CALM_ITEMS   = 300;
	// pipeline is three deep plus one bubble on one-row frames
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	// long receiver hold-off so the pipeline fills and input stalls
	localparam int HOLD_CYCLES   = 300;
	// longest legal quiet stretch is the hold-off plus a stall burst and a settle,
	// so this is several times over
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 command;
	logic [7:0]           red_in, green_in, blue_in;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           red_out, green_out, blue_out;
	logic                 end_of_frame;

	median_scoreboard sb;

	// idling controls for the sender and the receiver, and the count of items sent
	bit          sender_gaps;
	bit          stall_enable;
	bit          sink_hold_req;
	int unsigned items_sent;

	rgb_median3x3_filter_core #(
		.MAX_WIDTH(DEF_MAX_WIDTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.end_of_frame(end_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_t p;
		p.r = r;
		p.g = g;
		p.b = b;
		return p;
	endfunction

	// mode 1 keeps to the range ends, mode 2 to a narrow band full of ties
	function automatic logic [7:0] random_sample(int mode);
		logic [7:0] v;
		case (mode)
			1: begin
				v = 8'($urandom_range(0, 3));
				if (v > 8'd1) v = v + 8'd252;
			end
			2: v = 8'($urandom_range(100, 103));
			default: v = 8'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	function automatic pixel_t random_pixel(int mode);
		return make_pixel(random_sample(mode), random_sample(mode), random_sample(mode));
	endfunction

	// sampled at the rising edge: output check first so a result can never
	// match an expectation pushed in the same cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(red_out, green_out, blue_out, end_of_frame);
			if (in_valid && in_ready)
				sb.note_item(command, make_pixel(red_in, green_in, blue_in));
		end
	end

	// receiver: short random stalls, plus the one long hold-off on request
	initial begin : sink
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall_enable && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	// ends the run if neither channel moves an item for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("timeout: %0d cycles without an item moving, %0d results outstanding",
			quiet, sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// one item, held until accepted; a random gap may come first
	task automatic send_item(logic cmd, pixel_t px);
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		red_in   <= px.r;
		green_in <= px.g;
		blue_in  <= px.b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// stop offering, let every expected result out, then the pipeline latency
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.write_register(idx, data);
	endtask

	task automatic configure_frame(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
		settle();
		write_reg(CFG_FRAME_WIDTH, wv);
		write_reg(CFG_FRAME_HEIGHT, hv);
	endtask

	// one frame in raster order, then the drain items that flush it;
	// with abort_at set the frame stops early and the caller restarts it
	task automatic run_frame(input int pix_mode, input int abort_at, input int hold_at,
			output bit aborted);
		int w, h, total, n_pix, n_tail;
		w       = sb.eff_width();
		h       = sb.eff_height();
		total   = w * h;
		n_pix   = (abort_at > 0 && abort_at < total) ? abort_at : total;
		aborted = (n_pix < total);
		for (int p = 0; p < n_pix; p++) begin
			if (p == hold_at) sink_hold_req = 1'b1;
			// drain before the last pixel does nothing
			if ($urandom_range(0, 24) == 0) send_item(CMD_DRAIN, random_pixel(0));
			send_item(CMD_PIXEL, random_pixel(pix_mode));
		end
		if (aborted) return;
		// pending results; a pixel here counts as a drain and its samples are dropped
		n_tail = (total < w + 1) ? total : w + 1;
		for (int i = 0; i < n_tail; i++)
			send_item(($urandom_range(0, 7) == 0) ? CMD_PIXEL : CMD_DRAIN, random_pixel(0));
		// drains with nothing pending
		repeat ($urandom_range(0, 2)) send_item(CMD_DRAIN, random_pixel(0));
	endtask

	initial begin : stimulus
		int unsigned     random_start, sel;
		int              frame_no, abort_at;
		bit              must_config, aborted;
		logic [CFG_W-1:0] wv, hv;

		sb            = new();
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = CFG_FRAME_WIDTH;
		cfg_data      = '0;
		in_valid      = 1'b0;
		command       = CMD_PIXEL;
		red_in        = '0;
		green_in      = '0;
		blue_in       = '0;
		sender_gaps   = 1'b1;
		stall_enable  = 1'b1;
		sink_hold_req = 1'b0;
		items_sent    = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: drain straight after reset, nothing has been taken
		send_item(CMD_DRAIN, make_pixel(8'hFF, 8'hFF, 8'hFF));

		// 3x2 frame with range extremes, an early drain, a pixel while draining
		configure_frame(16'd3, 16'd2);
		send_item(CMD_PIXEL, make_pixel(8'd0, 8'd0, 8'd0));
		send_item(CMD_PIXEL, make_pixel(8'd255, 8'd255, 8'd255));
		send_item(CMD_PIXEL, make_pixel(8'd0, 8'd255, 8'd0));
		send_item(CMD_DRAIN, make_pixel(8'd1, 8'd2, 8'd3));
		send_item(CMD_PIXEL, make_pixel(8'd255, 8'd0, 8'd255));
		send_item(CMD_PIXEL, make_pixel(8'd18, 8'd200, 8'd7));
		send_item(CMD_PIXEL, make_pixel(8'd255, 8'd255, 8'd0));
		send_item(CMD_DRAIN, make_pixel(8'd0, 8'd0, 8'd0));
		send_item(CMD_PIXEL, make_pixel(8'd9, 8'd9, 8'd9));
		send_item(CMD_DRAIN, make_pixel(8'd0, 8'd0, 8'd0));
		send_item(CMD_DRAIN, make_pixel(8'd0, 8'd0, 8'd0));
		// end of frame already given, this drain has nothing to push
		send_item(CMD_DRAIN, make_pixel(8'd77, 8'd77, 8'd77));

		// zero width (junk above the field) and zero height act as a 1x1 frame
		configure_frame(16'hF800, 16'd0);
		send_item(CMD_PIXEL, make_pixel(8'd200, 8'd100, 8'd50));
		send_item(CMD_DRAIN, make_pixel(8'd0, 8'd0, 8'd0));

		// tallest frame, cut short: the next register write restarts it
		configure_frame(16'd4, 16'hFFFF);
		repeat (8) send_item(CMD_PIXEL, random_pixel(0));

		// random frames
		random_start = items_sent;
		must_config  = 1'b1;
		frame_no     = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (items_sent - random_start > RANDOM_ITEMS - CALM_ITEMS) begin
				sender_gaps  = 1'b0;
				stall_enable = 1'b0;
			end else begin
				sender_gaps  = ($urandom_range(0, 3) != 0);
				stall_enable = ($urandom_range(0, 3) != 0);
			end
			if (frame_no == 0) begin
				// all-ones width field clamps to the line store depth, cut after a few results
				configure_frame(16'hFFFF, 16'hFFFF);
				run_frame(1, DEF_MAX_WIDTH + 6, -1, aborted);
				must_config = 1'b1;
			end else if (frame_no == 2) begin
				// receiver holds off while the sender keeps offering
				sender_gaps = 1'b0;
				configure_frame(16'd8, 16'd8);
				run_frame(0, 0, 10, aborted);
				must_config = 1'b0;
			end else begin
				sel = $urandom_range(0, 19);
				if (sel < 11)       wv = 16'($urandom_range(1, 8));
				else if (sel < 15)  wv = 16'($urandom_range(9, 48));
				else if (sel == 15) wv = 16'($urandom_range(0, 31)) << 11;
				else if (sel == 16) wv = (16'($urandom_range(1, 31)) << 11)
					| 16'($urandom_range(1, 6));
				else                wv = 16'($urandom_range(1, 3));
				sel = $urandom_range(0, 9);
				if (wv[WIDTH_W-1:0] > 16) hv = 16'($urandom_range(1, 4));
				else if (sel < 6)         hv = 16'($urandom_range(1, 6));
				else if (sel < 8)         hv = 16'($urandom_range(7, 24));
				else if (sel == 8)        hv = 16'd0;
				else                      hv = 16'd1;
				abort_at = 0;
				if ($urandom_range(0, 7) == 0) begin
					hv       = 16'($urandom_range(2, 65535));
					abort_at = $urandom_range(1, 60);
				end
				// without a write the next pixel after end of frame starts a new one
				if (must_config || abort_at != 0 || $urandom_range(0, 3) != 0)
					configure_frame(wv, hv);
				run_frame($urandom_range(0, 2), abort_at, -1, aborted);
				must_config = aborted;
			end
			frame_no++;
		end

		// wind down: everything out, then a few more cycles for strays
		sender_gaps  = 1'b0;
		stall_enable = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d pixel items and %0d drain items over %0d frame setups,",
			sb.pixel_items, sb.drain_items, frame_no + 4);
		$display("%0d filtered pixels checked, %0d frames ended, %0d mismatches",
			sb.checked, sb.frames_done, sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
